>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the keypad RTL.
// No dependencies; assertions are compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/kpd_pkg.sv
// Package for the keypad debounce and event encoder: item types, state type,
// key table lookups. No dependencies.
`timescale 1ns / 1ps

package kpd_pkg;

  localparam int unsigned NumKeys    = 16;
  localparam int unsigned KeyIdxW    = 4;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned DebounceW  = 16;
  localparam logic [DebounceW-1:0] DebounceReset = 16'd30;
  localparam logic [7:0] NoKey = 8'h00;

  typedef logic [NumKeys-1:0] key_mask_t;
  typedef logic [7:0]         key_code_t;

  typedef struct packed {
    key_mask_t        raw_keys;
    logic [TimeW-1:0] now_ms;
    logic             pop_request;
    key_code_t        query_key;
  } in_item_t;

  typedef struct packed {
    key_code_t popped_key;
    key_mask_t stable_keys;
    logic      query_down;
  } out_item_t;

  typedef struct packed {
    key_mask_t        last_raw;
    logic [TimeW-1:0] change_time;
    key_mask_t        stable_mask;
    key_code_t        pending_key;
  } kpd_state_t;

  // Key table, bit row*4+col: 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D
  function automatic key_code_t key_code(input logic [KeyIdxW-1:0] idx);
    key_code_t code;
    case (idx)
      4'd0:    code = 8'h31;  // '1'
      4'd1:    code = 8'h32;  // '2'
      4'd2:    code = 8'h33;  // '3'
      4'd3:    code = 8'h41;  // 'A'
      4'd4:    code = 8'h34;  // '4'
      4'd5:    code = 8'h35;  // '5'
      4'd6:    code = 8'h36;  // '6'
      4'd7:    code = 8'h42;  // 'B'
      4'd8:    code = 8'h37;  // '7'
      4'd9:    code = 8'h38;  // '8'
      4'd10:   code = 8'h39;  // '9'
      4'd11:   code = 8'h43;  // 'C'
      4'd12:   code = 8'h2A;  // '*'
      4'd13:   code = 8'h30;  // '0'
      4'd14:   code = 8'h23;  // '#'
      default: code = 8'h44;  // 'D'
    endcase
    return code;
  endfunction

  // Code of the lowest set bit, NoKey when the mask is empty
  function automatic key_code_t lowest_code(input key_mask_t mask);
    key_code_t code;
    code = NoKey;
    for (int b = NumKeys - 1; b >= 0; b--) begin
      if (mask[b]) code = key_code(KeyIdxW'(b));
    end
    return code;
  endfunction

  // Stable state of the key with the given code, 0 when the code is not a key
  function automatic logic key_is_down(input key_code_t code, input key_mask_t mask);
    logic down;
    down = 1'b0;
    for (int b = 0; b < NumKeys; b++) begin
      if (key_code(KeyIdxW'(b)) == code) down = mask[b];
    end
    return down;
  endfunction

endpackage

>>> hw/rtl/kpd_in_if.sv
// Input channel: valid/ready handshake carrying one scan item.
// Depends on kpd_pkg.
`timescale 1ns / 1ps

interface kpd_in_if;
  logic                         valid;
  logic                         ready;
  kpd_pkg::key_mask_t           raw_keys;
  logic [kpd_pkg::TimeW-1:0]    now_ms;
  logic                         pop_request;
  kpd_pkg::key_code_t           query_key;

  modport source (output valid, raw_keys, now_ms, pop_request, query_key, input ready);
  modport sink   (input valid, raw_keys, now_ms, pop_request, query_key, output ready);
endinterface

>>> hw/rtl/kpd_out_if.sv
// Result channel: valid/ready handshake carrying one result item.
// Depends on kpd_pkg.
`timescale 1ns / 1ps

interface kpd_out_if;
  logic               valid;
  logic               ready;
  kpd_pkg::key_code_t popped_key;
  kpd_pkg::key_mask_t stable_keys;
  logic               query_down;

  modport source (output valid, popped_key, stable_keys, query_down, input ready);
  modport sink   (input valid, popped_key, stable_keys, query_down, output ready);
endinterface

>>> hw/rtl/kpd_update.sv
// Combinational update for one scan item: debounce, event capture, pop, query.
// Depends on kpd_pkg.
`timescale 1ns / 1ps

module kpd_update (
  input  kpd_pkg::in_item_t             item,
  input  kpd_pkg::kpd_state_t           cur,
  input  logic [kpd_pkg::DebounceW-1:0] debounce_ms,
  output kpd_pkg::kpd_state_t           nxt,
  output kpd_pkg::out_item_t            res
);
  import kpd_pkg::*;

  logic [TimeW-1:0] change_time;
  logic [TimeW-1:0] elapsed;
  logic             settle;
  key_mask_t        pressed;
  key_code_t        pend_upd;

  always_comb begin
    // Track raw changes and their time
    change_time = (item.raw_keys != cur.last_raw) ? item.now_ms : cur.change_time;
    elapsed     = item.now_ms - change_time;  // wraps modulo 2^32
    settle      = (elapsed >= {{(TimeW-DebounceW){1'b0}}, debounce_ms}) &&
                  (item.raw_keys != cur.stable_mask);
    pressed     = item.raw_keys & ~cur.stable_mask;

    nxt.last_raw    = item.raw_keys;
    nxt.change_time = change_time;
    nxt.stable_mask = settle ? item.raw_keys : cur.stable_mask;

    // New press latches only into an empty event slot
    pend_upd = cur.pending_key;
    if (settle && (pressed != '0) && (cur.pending_key == NoKey)) begin
      pend_upd = lowest_code(pressed);
    end

    // Pop after the update
    nxt.pending_key = item.pop_request ? NoKey : pend_upd;
    res.popped_key  = item.pop_request ? pend_upd : NoKey;
    res.stable_keys = nxt.stable_mask;
    res.query_down  = key_is_down(item.query_key, nxt.stable_mask);
  end

endmodule

>>> hw/rtl/keypad_debounce_event_encoder.sv
// Top level of the keypad debounce and event encoder.
// Depends on kpd_pkg, kpd_in_if, kpd_out_if, kpd_update and assert_macros.svh.
//
//   Channel   Direction  Handshake      Payload
//   in_ch     sink       valid/ready    raw_keys, now_ms, pop_request, query_key
//   out_ch    source     valid/ready    popped_key, stable_keys, query_down
//   cfg       write      cfg_wr_en      cfg_wr_data (debounce_ms)
//
// One item per cycle sustained while out_ch is not stalled; an accepted item passes
// through the input register, then the update logic into the result register.
// The key state updates as an item moves from the input register to the result
// register, so items are processed strictly in order.
// A stalled result holds the result register, and the input register once it
// is full; in_ch.ready is high while the input register is empty, the result
// register is empty, or the result is being taken.
// Synchronous active-low reset clears both stages, the key state, and sets
// debounce_ms to 30.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module keypad_debounce_event_encoder (
  input  logic                          clk,
  input  logic                          rst_n,
  kpd_in_if.sink                        in_ch,
  kpd_out_if.source                     out_ch,
  input  logic                          cfg_wr_en,
  input  logic [kpd_pkg::DebounceW-1:0] cfg_wr_data
);
  import kpd_pkg::*;

  logic [DebounceW-1:0] debounce_r;
  in_item_t             in_r;
  logic                 in_valid_r;
  out_item_t            out_r;
  logic                 out_valid_r;
  kpd_state_t           state_r;
  kpd_state_t           state_nxt;
  out_item_t            res;
  logic                 advance;
  logic                 fire;

  // Pipeline moves when the result slot is free or being taken
  assign advance      = !out_valid_r || out_ch.ready;
  assign fire         = in_valid_r && advance;
  assign in_ch.ready  = !in_valid_r || advance;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.popped_key  = out_r.popped_key;
  assign out_ch.stable_keys = out_r.stable_keys;
  assign out_ch.query_down  = out_r.query_down;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DebounceReset;
    end else if (cfg_wr_en) begin
      debounce_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_r.raw_keys    <= in_ch.raw_keys;
      in_r.now_ms      <= in_ch.now_ms;
      in_r.pop_request <= in_ch.pop_request;
      in_r.query_key   <= in_ch.query_key;
    end
  end

  kpd_update u_update (
    .item        (in_r),
    .cur         (state_r),
    .debounce_ms (debounce_r),
    .nxt         (state_nxt),
    .res         (res)
  );

  // Key state, updated once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  // A processed item always shows up as a result next cycle
  `ASSERT_NEXT(a_fire_gives_result, clk, rst_n, fire, out_valid_r)
  // A pop leaves the event slot empty
  `ASSERT_NEXT(a_pop_clears, clk, rst_n, fire && in_r.pop_request, state_r.pending_key == NoKey)
  // The shown stable mask matches the state until the next item is processed
  `ASSERT_IMPLIES(a_stable_matches, clk, rst_n, out_valid_r, out_r.stable_keys == state_r.stable_mask)

endmodule
